>>> hw/rtl/assert_macros.svh
// assertion macros for the checker file of the telemetry decoder
// no dependencies; expects clk and rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define EITD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define EITD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/eitd_pkg.sv
// shared constants and types of the edge interval telemetry decoder
// no dependencies
package eitd_pkg;

  localparam int WORD_BITS     = 21;
  localparam int MAX_INTERVALS = 19;
  localparam int TICK_W        = 8;
  localparam int RUN_W         = 3;
  localparam int POS_W         = $clog2(WORD_BITS + 1);
  localparam int WIDX_W        = $clog2(WORD_BITS);
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = ((2 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - 2 * WORD_BITS;

  localparam logic [TICK_W-1:0] ONE_BIT_RST   = 8'd4;
  localparam logic [TICK_W-1:0] TWO_BIT_RST   = 8'd7;
  localparam logic [TICK_W-1:0] THREE_BIT_RST = 8'd13;
  localparam logic [TICK_W-1:0] FOUR_BIT_RST  = 8'd18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_BIT   = 2'd0,
    CFG_TWO_BIT   = 2'd1,
    CFG_THREE_BIT = 2'd2,
    CFG_FOUR_BIT  = 2'd3
  } cfg_idx_t;

  // command from the sequencer to the bit writer
  typedef struct packed {
    logic preset;
    logic write;
    logic level;
  } bit_cmd_t;

endpackage

>>> hw/rtl/edge_interval_telemetry_decoder.sv
// top level of the edge interval telemetry decoder: sequencer and result register
// depends on eitd_pkg, eitd_cfg_class and eitd_bit_unit
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tdata: interval_ticks; tuser: frame_start
//   out_     out  out_tvalid/out_tready  tdata: decoded_word, raw_word
//   cfg_     in   cfg_wr_en              cfg_index, cfg_wdata (8 bit thresholds)
//
// an interval of n bits (0 to 4) holds in_tready low from its transfer while the
// shared bit writer takes one line bit per cycle, and then while the run is closed;
// a lead-in or ignored interval leaves in_tready high
// a frame end waits in an emit step until the result register is free
// rst_n is synchronous; it presets the word to all ones and clears the sequencer
// out_tready low only holds the result register and, at a frame end, the emit step
module edge_interval_telemetry_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [eitd_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] interval_ticks
  input  logic                                 in_tuser,   // [0] frame_start
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [eitd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [20:0] decoded_word,
                                                           // [41:21] raw_word, rest zero
  input  logic                                 cfg_wr_en,
  input  logic [eitd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eitd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WRITE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t                               state_r, state_nxt;
  logic [eitd_pkg::RUN_W-1:0]           run_cnt_r, run_cnt_nxt;
  logic [eitd_pkg::CNT_W-1:0]           icount_r, icount_nxt;
  logic                                 level_r, level_nxt;
  logic                                 active_r, active_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [eitd_pkg::WORD_BITS-1:0]       raw_r, raw_nxt;
  logic [eitd_pkg::WORD_BITS-1:0]       dec_r, dec_nxt;
  logic [eitd_pkg::CNT_W-1:0]           icount_inc;
  logic [eitd_pkg::RUN_W-1:0]           run_len;
  logic [eitd_pkg::WORD_BITS-1:0]       word;
  logic [eitd_pkg::TICK_W-1:0]          ticks;
  logic                                 in_xfer;
  eitd_pkg::bit_cmd_t                   cmd;

  assign ticks      = in_tdata[eitd_pkg::TICK_W-1:0];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign icount_inc = icount_r + 1'b1;

  // thresholds and the run length of the interval on the bus
  eitd_cfg_class u_class (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ticks     (ticks),
    .run_len   (run_len)
  );

  // one line bit per cycle into the word while a write is commanded, until the word is full
  eitd_bit_unit u_bits (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .word  (word)
  );

  always_comb begin
    state_nxt     = state_r;
    run_cnt_nxt   = run_cnt_r;
    icount_nxt    = icount_r;
    level_nxt     = level_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    raw_nxt       = raw_r;
    dec_nxt       = dec_r;
    cmd.preset    = 1'b0;
    cmd.write     = 1'b0;
    cmd.level     = level_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser) begin
            // lead-in: open a new frame, abandoning any open one
            cmd.preset = 1'b1;
            level_nxt  = 1'b0;
            icount_nxt = '0;
            active_nxt = 1'b1;
          end else if (active_r) begin
            if (ticks == '0) begin
              state_nxt = ST_EMIT;
            end else begin
              run_cnt_nxt = run_len;
              state_nxt   = ST_WRITE;
            end
          end
        end
      end
      ST_WRITE: begin
        if (run_cnt_r != '0) begin
          cmd.write   = 1'b1;
          run_cnt_nxt = run_cnt_r - 1'b1;
        end else begin
          // run done: flip level and count the interval, even a zero-bit one
          level_nxt  = ~level_r;
          icount_nxt = icount_inc;
          if (icount_inc >= eitd_pkg::CNT_W'(eitd_pkg::MAX_INTERVALS)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          raw_nxt       = word;
          dec_nxt       = word ^ (word >> 1);
          out_valid_nxt = 1'b1;
          active_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_cnt_r   <= '0;
      icount_r    <= '0;
      level_r     <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_cnt_r   <= run_cnt_nxt;
      icount_r    <= icount_nxt;
      level_r     <= level_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
    dec_r <= dec_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{eitd_pkg::OUT_PAD_W{1'b0}}, raw_r, dec_r};

endmodule

>>> hw/rtl/eitd_cfg_class.sv
// threshold registers and interval classifier of the telemetry decoder
// depends on eitd_pkg
module eitd_cfg_class (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [eitd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eitd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [eitd_pkg::TICK_W-1:0]         ticks,
  output logic [eitd_pkg::RUN_W-1:0]          run_len
);

  logic [eitd_pkg::TICK_W-1:0] one_r, two_r, three_r, four_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_r   <= eitd_pkg::ONE_BIT_RST;
      two_r   <= eitd_pkg::TWO_BIT_RST;
      three_r <= eitd_pkg::THREE_BIT_RST;
      four_r  <= eitd_pkg::FOUR_BIT_RST;
    end else if (cfg_wr_en) begin
      case (eitd_pkg::cfg_idx_t'(cfg_index))
        eitd_pkg::CFG_ONE_BIT:   one_r   <= cfg_wdata;
        eitd_pkg::CFG_TWO_BIT:   two_r   <= cfg_wdata;
        eitd_pkg::CFG_THREE_BIT: three_r <= cfg_wdata;
        eitd_pkg::CFG_FOUR_BIT:  four_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // priority from the longest run down, also for unordered thresholds
  always_comb begin
    if (ticks >= four_r)       run_len = 3'd4;
    else if (ticks >= three_r) run_len = 3'd3;
    else if (ticks >= two_r)   run_len = 3'd2;
    else if (ticks >= one_r)   run_len = 3'd1;
    else                       run_len = 3'd0;
  end

endmodule

>>> hw/rtl/eitd_bit_unit.sv
// shared bit writer: holds the line word and its fill position
// depends on eitd_pkg
module eitd_bit_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  eitd_pkg::bit_cmd_t                cmd,
  output logic [eitd_pkg::WORD_BITS-1:0]    word
);

  logic [eitd_pkg::WORD_BITS-1:0] word_r, word_nxt;
  logic [eitd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [eitd_pkg::WIDX_W-1:0]    idx;

  // msb first: position 0 lands on the top bit
  assign idx = eitd_pkg::WIDX_W'(eitd_pkg::WORD_BITS - 1) - pos_r[eitd_pkg::WIDX_W-1:0];

  always_comb begin
    word_nxt = word_r;
    pos_nxt  = pos_r;
    if (cmd.preset) begin
      word_nxt = '1;
      pos_nxt  = '0;
    end else if (cmd.write && (pos_r < eitd_pkg::POS_W'(eitd_pkg::WORD_BITS))) begin
      word_nxt[idx] = cmd.level;
      pos_nxt       = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '1;
      pos_r  <= '0;
    end else begin
      word_r <= word_nxt;
      pos_r  <= pos_nxt;
    end
  end

  assign word = word_r;

endmodule

>>> hw/rtl/eitd_checker.sv
// port-level checks of the telemetry decoder, bound to the top level
// depends on eitd_pkg and assert_macros.svh
`include "assert_macros.svh"

module eitd_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [eitd_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [eitd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic [eitd_pkg::WORD_BITS-1:0] raw_w, dec_w;
  logic                           in_xfer;

  assign dec_w   = out_tdata[eitd_pkg::WORD_BITS-1:0];
  assign raw_w   = out_tdata[2*eitd_pkg::WORD_BITS-1:eitd_pkg::WORD_BITS];
  assign in_xfer = in_tvalid & in_tready & (in_tdata == in_tdata);

  // a stalled result holds
  `EITD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // decoded word always matches the raw word shown beside it
  `EITD_ASSERT(a_decode, out_tvalid |-> dec_w == (raw_w ^ (raw_w >> 1)), "decoded word mismatch")

  // a lead-in never produces a result
  `EITD_ASSERT(a_lead_in, in_xfer && in_tuser && !out_tvalid |=> !out_tvalid, "result after lead-in")

  // reset empties the result register
  `EITD_ASSERT_RST(a_reset, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind edge_interval_telemetry_decoder eitd_checker u_eitd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
